// File: rtl/bale_pkg.sv
// Shared types and constants for the bounded array list engine.
// No dependencies; bale_dp, bale_ctrl and the core import this package.
package bale_pkg;

  // Default list capacity
  localparam int BALE_DEPTH = 128;

  // Request operation codes
  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_FIND   = 3'd4,
    OP_GET    = 3'd5
  } bale_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_EMPTY  = 2'd3
  } bale_status_t;

  // Request beat
  typedef struct packed {
    logic [2:0]         func;
    logic [7:0]         position;
    logic signed [31:0] value;
  } bale_in_t;

  // Result beat
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         found_position;
    logic [7:0]         count;
  } bale_out_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_TAIL,
    S_PUT,
    S_DONE
  } bale_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;   // capture the request beat and decode it
    logic sweep;  // issue one memory read of the walk
    logic put;    // write the inserted value at its position
    logic push;   // load the result into the output register
  } bale_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_sweep;  // decoded request walks the memory
    logic need_put;    // decoded request is an insert at the tail
    logic last;        // current read is the final one of the walk
    logic is_insert;   // request in flight is an insert
    logic out_free;    // output register can take a result this cycle
  } bale_sts_t;

endpackage

// File: rtl/bale_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/bale_dp.sv
// Datapath: length register, request decode, element memory walk and result register.
// Depends on bale_pkg and bale_ram.
module bale_dp import bale_pkg::*; #(
  parameter int DEPTH = BALE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  bale_cmd_t cmd,
  output bale_sts_t sts,
  input  bale_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output bale_out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = ((LW > 8) ? LW : 8) + 1;

  // Registers
  logic [LW-1:0]      len_r, len_nxt;
  logic               lag_valid_r, lag_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         op_r;
  logic [31:0]        val_r;
  logic [AW-1:0]      pidx_r;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      end_r;
  logic [AW-1:0]      lag_idx_r;
  logic [1:0]         res_status_r, res_status_nxt;
  logic [31:0]        res_read_r, res_read_nxt;
  logic [7:0]         res_found_r, res_found_nxt;
  logic               hit_r, hit_nxt;
  bale_out_t          out_data_r;

  // Decode
  logic [CW-1:0]      pos_ext, len_ext;
  logic               full, empty, ins_ok, sel_ok;
  logic [AW-1:0]      pos_idx, len_idx, tail_idx;
  logic [1:0]         dec_status;
  logic               dec_sweep, dec_put, dec_app;
  logic [AW-1:0]      dec_start, dec_end;

  // Memory ports
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [31:0]        mem_wdata;
  logic [31:0]        mem_rdata;

  assign pos_ext  = CW'(in_data.position);
  assign len_ext  = CW'(len_r);
  assign full     = (len_r == LW'(DEPTH));
  assign empty    = (len_r == '0);
  assign ins_ok   = (pos_ext != '0) && (pos_ext <= len_ext + CW'(1));
  assign sel_ok   = (pos_ext != '0) && (pos_ext <= len_ext);
  assign pos_idx  = AW'(pos_ext - CW'(1));
  assign len_idx  = AW'(len_ext - CW'(1));
  assign tail_idx = AW'(len_r);

  // Decode the request against the current length
  always_comb begin
    dec_status = STAT_OK;
    dec_sweep  = 1'b0;
    dec_put    = 1'b0;
    dec_app    = 1'b0;
    dec_start  = pos_idx;
    dec_end    = pos_idx;
    case (in_data.func)
      OP_CLEAR: begin
        dec_status = STAT_OK;
      end
      OP_APPEND: begin
        if (full) begin
          dec_status = STAT_FULL;
        end else begin
          dec_app = 1'b1;
        end
      end
      OP_INSERT: begin
        if (full) begin
          dec_status = STAT_FULL;
        end else if (!ins_ok) begin
          dec_status = STAT_BADPOS;
        end else if (pos_ext <= len_ext) begin
          dec_sweep = 1'b1;
          dec_start = len_idx;
          dec_end   = pos_idx;
        end else begin
          dec_put = 1'b1;
        end
      end
      OP_DELETE: begin
        if (empty) begin
          dec_status = STAT_EMPTY;
        end else if (!sel_ok) begin
          dec_status = STAT_BADPOS;
        end else begin
          dec_sweep = 1'b1;
          dec_start = pos_idx;
          dec_end   = len_idx;
        end
      end
      OP_FIND: begin
        if (!empty) begin
          dec_sweep = 1'b1;
          dec_start = '0;
          dec_end   = len_idx;
        end
      end
      OP_GET: begin
        if (!sel_ok) begin
          dec_status = STAT_BADPOS;
        end else begin
          dec_sweep = 1'b1;
        end
      end
      default: begin
        dec_status = STAT_OK;
      end
    endcase
  end

  // Status toward the controller
  assign sts.need_sweep = dec_sweep;
  assign sts.need_put   = dec_put;
  assign sts.last       = (idx_r == end_r);
  assign sts.is_insert  = (op_r == OP_INSERT);
  assign sts.out_free   = !out_valid_r || out_ready;

  // Length update
  always_comb begin
    len_nxt = len_r;
    if (cmd.take) begin
      if (in_data.func == OP_CLEAR) begin
        len_nxt = '0;
      end else if (dec_app) begin
        len_nxt = len_r + LW'(1);
      end else if ((in_data.func == OP_DELETE) && dec_sweep) begin
        len_nxt = len_r - LW'(1);
      end
    end else if (cmd.put) begin
      len_nxt = len_r + LW'(1);
    end
  end

  // Walk pointer: down for insert, up otherwise
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.take) begin
      idx_nxt = dec_start;
    end else if (cmd.sweep) begin
      idx_nxt = (op_r == OP_INSERT) ? idx_r - AW'(1) : idx_r + AW'(1);
    end
  end

  assign lag_valid_nxt = cmd.sweep;

  // Handle read data in the cycle after each read; drive the write port
  always_comb begin
    res_status_nxt = res_status_r;
    res_read_nxt   = res_read_r;
    res_found_nxt  = res_found_r;
    hit_nxt        = hit_r;
    mem_we         = 1'b0;
    mem_waddr      = lag_idx_r;
    mem_wdata      = mem_rdata;
    if (cmd.take) begin
      res_status_nxt = dec_status;
      res_read_nxt   = '0;
      res_found_nxt  = '0;
      hit_nxt        = 1'b0;
      if (dec_app) begin
        mem_we    = 1'b1;
        mem_waddr = tail_idx;
        mem_wdata = in_data.value;
      end
    end else if (cmd.put) begin
      mem_we    = 1'b1;
      mem_waddr = pidx_r;
      mem_wdata = val_r;
    end else if (lag_valid_r) begin
      case (op_r)
        OP_INSERT: begin
          mem_we    = 1'b1;
          mem_waddr = lag_idx_r + AW'(1);
        end
        OP_DELETE: begin
          if (lag_idx_r == pidx_r) begin
            res_read_nxt = mem_rdata;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = lag_idx_r - AW'(1);
          end
        end
        OP_FIND: begin
          if (!hit_r && (mem_rdata == val_r)) begin
            hit_nxt       = 1'b1;
            res_found_nxt = 8'({1'b0, lag_idx_r} + (AW+1)'(1));
          end
        end
        OP_GET: begin
          res_read_nxt = mem_rdata;
        end
        default: begin
          hit_nxt = hit_r;
        end
      endcase
    end
  end

  // Output register: load on push, drop on a taken beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      lag_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      lag_valid_r <= lag_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= in_data.func;
      val_r  <= in_data.value;
      pidx_r <= pos_idx;
      end_r  <= dec_end;
    end
    idx_r        <= idx_nxt;
    lag_idx_r    <= idx_r;
    res_status_r <= res_status_nxt;
    res_read_r   <= res_read_nxt;
    res_found_r  <= res_found_nxt;
    hit_r        <= hit_nxt;
    if (cmd.push) begin
      out_data_r.status         <= res_status_r;
      out_data_r.read_value     <= $signed(res_read_r);
      out_data_r.found_position <= res_found_r;
      out_data_r.count          <= 8'(len_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Element store
  bale_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (cmd.sweep),
    .raddr(idx_r),
    .rdata(mem_rdata)
  );

endmodule

// File: rtl/bale_ctrl.sv
// Controller state machine: sequences decode, memory walk, insert write and result.
// Depends on bale_pkg.
module bale_ctrl import bale_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bale_sts_t sts,
  output bale_cmd_t cmd
);

  bale_state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.need_sweep) begin
            state_nxt = S_SWEEP;
          end else if (sts.need_put) begin
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SWEEP: begin
        if (sts.last) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        state_nxt = sts.is_insert ? S_PUT : S_DONE;
      end
      S_PUT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
      end
      S_PUT: begin
        cmd.put = 1'b1;
      end
      S_DONE: begin
        cmd.push = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/bounded_array_list_engine_core.sv
// Bounded array list engine: ordered list of up to DEPTH signed 32-bit values.
// Request beats enter on in_*, one result beat per request leaves on out_*.
// Both channels are valid/ready; a beat moves when valid and ready are high.
// Operations: clear, append, insert, delete, find first, get (1-based).
// Each result carries a status, the read value or found position and the new length.
// One request is in flight at a time; in_ready is high only while idle.
// Clear, append, unused codes and rejected requests go from idle straight to the
// result state. Get reads one entry. Insert at the tail writes in the put state.
// Insert, delete and find walk the element RAM one entry per cycle through
// its single read port; insert then writes its value in the put state.
// The result sits in an output register; the next request is taken while it
// waits. A stalled receiver holds the engine only once a second result is
// ready. Reset empties the list; the RAM needs no clearing, since only written
// entries are ever read.
// Depends on bale_pkg, bale_ctrl, bale_dp and bale_ram.
module bounded_array_list_engine_core import bale_pkg::*; #(
  parameter int DEPTH = BALE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bale_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output bale_out_t out_data
);

  bale_cmd_t cmd;
  bale_sts_t sts;

  // Sequencer
  bale_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // List storage and result path
  bale_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for bounded_array_list_engine_core: directed and random list traffic.
// Predicts each result from a shadow copy of the list; depends on bale_pkg and the rtl/ files.
module tb_top;
  import bale_pkg::*;

  localparam int LIST_CAP     = BALE_DEPTH;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 2 * LIST_CAP;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_ITEMS  = 150;
  localparam int REPORT_MAX   = 10;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  // Growth bias of one random phase
  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} mix_mode_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  bale_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  bale_out_t out_data;

  // Shadow list and the results it predicts, oldest first
  logic signed [31:0] shadow_list [LIST_CAP];
  int        shadow_len   = 0;
  bale_out_t pending_results [$];
  bale_out_t want;
  int        errors       = 0;
  int        results_seen = 0;
  int        idle_cycles  = 0;
  bit        idle_on      = 1'b0;
  bit        quiet        = 1'b0;

  always #4 clk = ~clk;

  bounded_array_list_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Apply one request to the shadow list and return the result it gives
  function automatic bale_out_t apply_request(bale_in_t req);
    bale_out_t res;
    int pos;
    int i;
    res = '0;
    pos = req.position;
    case (req.func)
      OP_CLEAR: shadow_len = 0;
      OP_APPEND: begin
        if (shadow_len >= LIST_CAP) begin
          res.status = STAT_FULL;
        end else begin
          shadow_list[shadow_len] = req.value;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        // full takes precedence over a bad position
        if (shadow_len >= LIST_CAP) begin
          res.status = STAT_FULL;
        end else if (pos < 1 || pos > shadow_len + 1) begin
          res.status = STAT_BADPOS;
        end else begin
          for (i = shadow_len; i >= pos; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[pos - 1] = req.value;
          shadow_len++;
        end
      end
      OP_DELETE: begin
        // empty takes precedence over a bad position
        if (shadow_len == 0) begin
          res.status = STAT_EMPTY;
        end else if (pos < 1 || pos > shadow_len) begin
          res.status = STAT_BADPOS;
        end else begin
          res.read_value = shadow_list[pos - 1];
          for (i = pos; i < shadow_len; i++) shadow_list[i - 1] = shadow_list[i];
          shadow_len--;
        end
      end
      OP_FIND: begin
        // keep only the first match
        for (i = 0; i < shadow_len; i++) begin
          if (res.found_position == 0 && shadow_list[i] == req.value) begin
            res.found_position = 8'(i + 1);
          end
        end
      end
      OP_GET: begin
        if (pos < 1 || pos > shadow_len) res.status = STAT_BADPOS;
        else res.read_value = shadow_list[pos - 1];
      end
      default: ;
    endcase
    res.count = 8'(shadow_len);
    return res;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("%s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      note_error($sformatf("result %0d %s: expected %0h, got %0h",
                           results_seen, name, exp_v, act_v));
    end
  endtask

  // Drive one request beat, with an optional gap ahead of it, and predict its result
  task automatic send_req(input bale_in_t req);
    int gap;
    gap = 0;
    if (idle_on && !quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_request(req));
  endtask

  task automatic send_op(input logic [2:0] func_code, input logic [7:0] pos,
                         input logic signed [31:0] val);
    bale_in_t req;
    req.func     = func_code;
    req.position = pos;
    req.value    = val;
    send_req(req);
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Hold the sender until every predicted result has come back
  task automatic wait_drained();
    hold_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Requests on an empty list, an unused code included
  task automatic test_empty_list();
    idle_on = 1'b1;
    send_op(OP_FIND, 8'd0, 32'sd0);
    send_op(OP_DELETE, 8'd0, 32'sd0);
    send_op(OP_GET, 8'd1, 32'sd0);
    send_op(OP_INSERT, 8'd0, 32'sd5);
    send_op(OP_INSERT, 8'd2, 32'sd5);
    send_op(OP_RSVD6, 8'hff, VAL_MAX);
    send_op(OP_CLEAR, 8'd0, 32'sd0);
  endtask

  // Head, middle and tail edits, duplicates and out-of-range positions
  task automatic test_edit_ops();
    send_op(OP_APPEND, 8'd0, VAL_MAX);
    send_op(OP_APPEND, 8'hff, VAL_MIN);
    send_op(OP_INSERT, 8'd1, 32'sd0);
    send_op(OP_INSERT, 8'd4, -32'sd1);
    send_op(OP_INSERT, 8'd2, 32'sd7);
    send_op(OP_INSERT, 8'd7, 32'sd9);
    send_op(OP_APPEND, 8'd0, 32'sd7);
    send_op(OP_FIND, 8'd0, 32'sd7);
    send_op(OP_FIND, 8'd0, VAL_MIN);
    send_op(OP_FIND, 8'd0, 32'sd12345);
    send_op(OP_GET, 8'd1, 32'sd0);
    send_op(OP_GET, 8'd6, 32'sd0);
    send_op(OP_GET, 8'd7, 32'sd0);
    send_op(OP_GET, 8'hff, 32'sd0);
    send_op(OP_DELETE, 8'd7, 32'sd0);
    send_op(OP_DELETE, 8'd6, 32'sd0);
    send_op(OP_DELETE, 8'd1, 32'sd0);
    send_op(OP_DELETE, 8'd2, 32'sd0);
    send_op(OP_RSVD7, 8'hff, VAL_MIN);
    send_op(OP_CLEAR, 8'hff, VAL_MAX);
  endtask

  // Fill to capacity, hit the full cases, then empty the list by deletes
  task automatic test_full_list();
    logic signed [31:0] v;
    while (shadow_len < LIST_CAP) begin
      if ($urandom_range(0, 7) == 0) v = int'($urandom_range(0, 8)) - 4;
      else v = $urandom;
      send_op(OP_APPEND, 8'($urandom_range(0, 255)), v);
    end
    send_op(OP_APPEND, 8'd1, 32'sd3);
    send_op(OP_INSERT, 8'd0, 32'sd3);
    send_op(OP_INSERT, 8'd129, 32'sd3);
    send_op(OP_GET, 8'(LIST_CAP), 32'sd0);
    send_op(OP_GET, 8'(LIST_CAP + 1), 32'sd0);
    send_op(OP_FIND, 8'd0, shadow_list[LIST_CAP - 1]);
    send_op(OP_DELETE, 8'(LIST_CAP), 32'sd0);
    send_op(OP_INSERT, 8'(LIST_CAP), VAL_MIN);
    send_op(OP_DELETE, 8'd1, 32'sd0);
    send_op(OP_INSERT, 8'd1, VAL_MAX);
    wait_drained();
    while (shadow_len > 0) send_op(OP_DELETE, 8'($urandom_range(1, shadow_len)), $urandom);
    send_op(OP_DELETE, 8'hff, 32'sd0);
  endtask

  // Build one random request biased by the phase mode
  task automatic send_random_req(input mix_mode_t mode);
    logic [2:0] f;
    logic signed [31:0] v;
    int pos;
    int len_now;
    int r;
    int grow_pct;
    int del_pct;
    len_now  = shadow_len;
    grow_pct = (mode == MODE_GROW) ? 65 : (mode == MODE_SHRINK) ? 20 : 40;
    del_pct  = (mode == MODE_GROW) ? 10 : (mode == MODE_SHRINK) ? 45 : 25;

    // pick the operation
    r = $urandom_range(0, 99);
    if (r < grow_pct) f = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
    else if (r < grow_pct + del_pct) f = OP_DELETE;
    else if (r < 96) f = $urandom_range(0, 1) ? OP_FIND : OP_GET;
    else if (r < 98) f = (mode == MODE_MIXED) ? OP_CLEAR : OP_GET;
    else f = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;

    // mostly legal positions, some at the edges, a few anywhere
    r = $urandom_range(0, 9);
    if (r < 8) begin
      if (f == OP_INSERT) pos = $urandom_range(1, len_now + 1);
      else pos = $urandom_range(1, (len_now == 0) ? 1 : len_now);
    end else if (r < 9) begin
      case ($urandom_range(0, 3))
        0: pos = 0;
        1: pos = len_now;
        2: pos = len_now + 1;
        default: pos = len_now + 2;
      endcase
    end else begin
      pos = $urandom_range(0, 255);
    end

    // small values make duplicates; finds often look for a stored value
    r = $urandom_range(0, 9);
    if (f == OP_FIND && len_now > 0 && r < 5) v = shadow_list[$urandom_range(0, len_now - 1)];
    else if (r < 3) v = int'($urandom_range(0, 8)) - 4;
    else if (r == 3) v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    else v = $urandom;

    send_op(f, 8'(pos), v);
  endtask

  // Random phases; drain between phases and run the last one without idling
  task automatic test_random_mix();
    mix_mode_t mode;
    int sent;
    sent = 0;
    mode = MODE_GROW;
    while (sent < RANDOM_ITEMS) begin
      if (sent % PHASE_ITEMS == 0) begin
        wait_drained();
        mode    = mix_mode_t'($urandom_range(0, 2));
        idle_on = ($urandom_range(0, 3) != 0);
        quiet   = (sent + PHASE_ITEMS >= RANDOM_ITEMS);
      end
      send_random_req(mode);
      sent++;
    end
  endtask

  // Stall the result channel in random bursts
  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (rst_n && idle_on && !quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_error($sformatf("result %0d arrived with no request pending", results_seen));
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("read_value", want.read_value, out_data.read_value);
        check_field("found_position", 32'(want.found_position),
                    32'(out_data.found_position));
        check_field("count", 32'(want.count), 32'(out_data.count));
      end
    end
  end

  // End the run when no beat moves for too long
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("no beat moved for %0d cycles", STALL_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_edit_ops();
    test_full_list();
    test_random_mix();
    hold_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
